// ===== hdl/kmt_pkg.sv =====
// Shared constants and types for the k-way merge tournament tree.
`timescale 1ns / 1ps

package kmt_pkg;

    localparam int LANES_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 16;

    // op field codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLIMB,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/kway_merge_tournament_tree.sv =====
// Top level: sequencer that walks one leaf-to-root path of the tournament tree.
`timescale 1ns / 1ps
//
// channel  dir  tdata (low bit up)          tuser (low bit up)
// s_*      in   lane, key                   op, present
// m_*      out  min_key, min_lane           any_present
//
// A leaf update does the leaf write, then one node RAM read and one compare
// per tree level. A write to a lane beyond LANES changes no node and reports
// the current root. A clear sweeps all 2**ADDR_W node entries, one per cycle,
// then reports; after reset the same sweep runs with s_tready low. A new
// request is taken while the last result waits in the output register; the
// climb holds at the root until that register is free.

module kway_merge_tournament_tree #(
    parameter int LANES     = kmt_pkg::LANES_DEF,
    parameter int KEY_WIDTH = kmt_pkg::KEY_WIDTH_DEF,
    localparam int LANE_W   = $clog2(LANES),
    localparam int IN_W     = ((LANE_W + KEY_WIDTH + 7) / 8) * 8,
    localparam int OUT_W    = ((KEY_WIDTH + LANE_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // lane, key
    input  logic [1:0]       s_tuser,   // op, present
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // min_key, min_lane
    output logic [0:0]       m_tuser    // any_present
);

    localparam int LEVELS = LANE_W;
    localparam int ADDR_W = LEVELS + 1;
    localparam int NODE_W = KEY_WIDTH + LANE_W + 1;
    localparam int PRES_BIT = NODE_W - 1;

    kmt_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [NODE_W-1:0] carry_reg, carry_next;
    logic [NODE_W-1:0] root_reg, root_next;
    logic              report_reg, report_next;

    logic                 m_valid_reg;
    logic [KEY_WIDTH-1:0] m_key_reg;
    logic [LANE_W-1:0]    m_lane_reg;
    logic                 m_any_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [NODE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [NODE_W-1:0] ram_rdata;
    logic [NODE_W-1:0] winner;

    logic              load_out;
    logic [NODE_W-1:0] out_node;
    logic              out_free;

    logic                 in_op;
    logic                 in_present;
    logic [LANE_W-1:0]    in_lane;
    logic [KEY_WIDTH-1:0] in_key;
    logic                 in_range;
    logic [ADDR_W-1:0]    leaf_addr;
    logic [NODE_W-1:0]    leaf_node;
    logic [ADDR_W-1:0]    parent_addr;

    assign in_op      = s_tuser[0];
    assign in_present = s_tuser[1];
    assign in_lane    = s_tdata[LANE_W-1:0];
    assign in_key     = s_tdata[LANE_W+KEY_WIDTH-1:LANE_W];
    assign in_range   = {1'b0, in_lane} < (LANE_W + 1)'(LANES);
    assign leaf_addr  = {1'b1, in_lane};
    assign leaf_node  = {in_present, in_lane, in_present ? in_key : {KEY_WIDTH{1'b0}}};
    assign parent_addr = addr_reg >> 1;
    assign out_free   = !m_valid_reg || m_tready;

    kmt_node_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (NODE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kmt_node_cmp #(
        .KEY_W  (KEY_WIDTH),
        .LANE_W (LANE_W)
    ) u_cmp (
        .child  (carry_reg),
        .sib    (ram_rdata),
        .winner (winner)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kmt_pkg::ST_CLEAR;
            sweep_reg   <= '0;
            report_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            report_reg <= report_next;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        carry_reg <= carry_next;
        root_reg  <= root_next;
        if (load_out)
        begin
            m_any_reg  <= out_node[PRES_BIT];
            m_key_reg  <= out_node[PRES_BIT] ? out_node[KEY_WIDTH-1:0] : '0;
            m_lane_reg <= out_node[PRES_BIT] ? out_node[PRES_BIT-1:KEY_WIDTH] : '0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        sweep_next  = sweep_reg;
        carry_next  = carry_reg;
        root_next   = root_reg;
        report_next = report_reg;
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        ram_wdata   = '0;
        ram_raddr   = addr_reg ^ ADDR_W'(1);
        s_tready    = 1'b0;
        load_out    = 1'b0;
        out_node    = root_reg;

        case (state_reg)
            kmt_pkg::ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == {ADDR_W{1'b1}})
                begin
                    root_next  = '0;
                    state_next = report_reg ? kmt_pkg::ST_DONE : kmt_pkg::ST_IDLE;
                    report_next = 1'b0;
                end
            end
            kmt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (in_op == kmt_pkg::OP_CLEAR)
                    begin
                        sweep_next  = '0;
                        report_next = 1'b1;
                        state_next  = kmt_pkg::ST_CLEAR;
                    end
                    else if (!in_range)
                    begin
                        state_next = kmt_pkg::ST_DONE;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = leaf_addr;
                        ram_wdata  = leaf_node;
                        ram_raddr  = leaf_addr ^ ADDR_W'(1);
                        addr_next  = leaf_addr;
                        carry_next = leaf_node;
                        state_next = kmt_pkg::ST_CLIMB;
                    end
                end
            end
            kmt_pkg::ST_CLIMB:
            begin
                if (parent_addr != ADDR_W'(1))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = parent_addr;
                    ram_wdata  = winner;
                    ram_raddr  = parent_addr ^ ADDR_W'(1);
                    addr_next  = parent_addr;
                    carry_next = winner;
                end
                else if (out_free)
                begin
                    // root lives in a register; it is never read as a sibling
                    root_next  = winner;
                    out_node   = winner;
                    load_out   = 1'b1;
                    state_next = kmt_pkg::ST_IDLE;
                end
            end
            kmt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = kmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kmt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_lane_reg, m_key_reg});
    assign m_tuser  = m_any_reg;

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_any_reg |-> m_key_reg == '0 && m_lane_reg == '0)
        else $error("empty result carries nonzero key or lane");

    a_climb_addr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kmt_pkg::ST_CLIMB |-> addr_reg > ADDR_W'(1))
        else $error("climb pointer left the tree");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && state_reg != kmt_pkg::ST_CLEAR |-> ram_waddr > ADDR_W'(1))
        else $error("path write to root or unused node");

    a_root_lane: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && out_node[PRES_BIT] |->
            {1'b0, out_node[PRES_BIT-1:KEY_WIDTH]} < (LANE_W + 1)'(LANES))
        else $error("winner lane out of range");

endmodule

// ===== hdl/kmt_node_ram.sv =====
// Node store of the tree: one write port, one registered read port.
`timescale 1ns / 1ps

module kmt_node_ram #(
    parameter int ADDR_W = 5,
    parameter int DATA_W = 21
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/kmt_node_cmp.sv =====
// Match unit: picks the winner of an updated child and its sibling.
`timescale 1ns / 1ps

module kmt_node_cmp #(
    parameter int KEY_W  = 16,
    parameter int LANE_W = 4
) (
    input  logic [KEY_W+LANE_W:0] child,
    input  logic [KEY_W+LANE_W:0] sib,
    output logic [KEY_W+LANE_W:0] winner
);

    localparam int PRES_BIT = KEY_W + LANE_W;

    logic child_wins;

    // sibling takes ties; an empty node loses to any key
    always_comb
    begin
        child_wins = child[PRES_BIT] &&
                     (!sib[PRES_BIT] ||
                      ($signed(child[KEY_W-1:0]) < $signed(sib[KEY_W-1:0])));
        winner = child_wins ? child : sib;
    end

endmodule
